@@ hw/rtl/bracket_balance_checker_core_defines.svh @@
// assertion macros used by the checker control module (bbc_ctrl)
`ifndef BRACKET_BALANCE_CHECKER_CORE_DEFINES_SVH
`define BRACKET_BALANCE_CHECKER_CORE_DEFINES_SVH

// property must hold at every edge outside reset
`define BBC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bbc assertion failed");

// expression must never be true outside reset
`define BBC_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("bbc forbidden condition");

`endif

@@ hw/rtl/bbc_pkg.sv @@
`timescale 1ns / 1ps
package bbc_pkg;

  localparam int CODE_W = 3;

  // stack entry codes
  localparam logic [CODE_W-1:0] CODE_ROUND  = 3'd1;
  localparam logic [CODE_W-1:0] CODE_SQUARE = 3'd2;
  localparam logic [CODE_W-1:0] CODE_CURLY  = 3'd3;
  localparam logic [CODE_W-1:0] CODE_ANGLE  = 3'd4;
  localparam logic [CODE_W-1:0] CODE_BAR    = 3'd5;

  // ascii symbols
  localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;
  localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
  localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
  localparam logic [7:0] CH_OPEN_ANGLE   = 8'h3C;
  localparam logic [7:0] CH_BAR          = 8'h7C;
  localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
  localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
  localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;
  localparam logic [7:0] CH_CLOSE_ANGLE  = 8'h3E;

  typedef logic [CODE_W-1:0] code_t;

  // shift command broadcast to every stack cell
  typedef struct packed {
    logic  push;
    logic  pop;
    code_t code;
  } stack_ctl_t;

endpackage

@@ hw/rtl/bbc_in_if.sv @@
`timescale 1ns / 1ps
interface bbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last_symbol;

  modport source (output valid, output symbol, output last_symbol, input ready);
  modport sink (input valid, input symbol, input last_symbol, output ready);
endinterface

@@ hw/rtl/bbc_out_if.sv @@
`timescale 1ns / 1ps
interface bbc_out_if;
  logic valid;
  logic ready;
  logic balanced;
  logic overflowed;

  modport source (output valid, output balanced, output overflowed, input ready);
  modport sink (input valid, input balanced, input overflowed, output ready);
endinterface

@@ hw/rtl/bbc_cell.sv @@
`timescale 1ns / 1ps
module bbc_cell (
  input  logic               clk,
  input  bbc_pkg::stack_ctl_t ctl,
  input  bbc_pkg::code_t     from_prev,
  input  bbc_pkg::code_t     from_next,
  output bbc_pkg::code_t     held
);

  // push shifts away from the top, pop shifts toward it
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      held <= from_prev;
    end else if (ctl.pop) begin
      held <= from_next;
    end
  end

endmodule

@@ hw/rtl/bbc_ctrl.sv @@
`timescale 1ns / 1ps
`include "bracket_balance_checker_core_defines.svh"
module bbc_ctrl #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  bbc_in_if.sink              chars,
  bbc_out_if.source           verdict,
  input  bbc_pkg::code_t      top_code,
  output bbc_pkg::stack_ctl_t ctl
);

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam logic [DW-1:0] FULL = DW'(STACK_DEPTH);

  logic [DW-1:0]  depth;
  logic [DW-1:0]  depth_next;
  logic           failed;
  logic           failed_next;
  logic           overflow_seen;
  logic           overflow_seen_next;
  logic           acc;
  logic           empty;
  logic           full;
  logic           push_want;
  logic           close_want;
  bbc_pkg::code_t want_code;
  bbc_pkg::code_t push_code;

  assign acc         = chars.valid && chars.ready;
  assign empty       = (depth == '0);
  assign full        = (depth == FULL);
  assign chars.ready = !verdict.valid || verdict.ready;

  always_comb begin
    push_want          = 1'b0;
    close_want         = 1'b0;
    want_code          = bbc_pkg::CODE_ROUND;
    push_code          = bbc_pkg::CODE_ROUND;
    ctl.push           = 1'b0;
    ctl.pop            = 1'b0;
    ctl.code           = bbc_pkg::CODE_ROUND;
    failed_next        = failed;
    overflow_seen_next = overflow_seen;
    depth_next         = depth;
    if (acc && !failed) begin
      unique case (chars.symbol)
        bbc_pkg::CH_OPEN_ROUND: begin
          push_want = 1'b1;
          push_code = bbc_pkg::CODE_ROUND;
        end
        bbc_pkg::CH_OPEN_SQUARE: begin
          push_want = 1'b1;
          push_code = bbc_pkg::CODE_SQUARE;
        end
        bbc_pkg::CH_OPEN_CURLY: begin
          push_want = 1'b1;
          push_code = bbc_pkg::CODE_CURLY;
        end
        bbc_pkg::CH_OPEN_ANGLE: begin
          push_want = 1'b1;
          push_code = bbc_pkg::CODE_ANGLE;
        end
        bbc_pkg::CH_BAR: begin
          // a bar closes a bar on top, otherwise it opens
          if (!empty && top_code == bbc_pkg::CODE_BAR) begin
            ctl.pop = 1'b1;
          end else begin
            push_want = 1'b1;
            push_code = bbc_pkg::CODE_BAR;
          end
        end
        bbc_pkg::CH_CLOSE_ROUND: begin
          close_want = 1'b1;
          want_code  = bbc_pkg::CODE_ROUND;
        end
        bbc_pkg::CH_CLOSE_SQUARE: begin
          close_want = 1'b1;
          want_code  = bbc_pkg::CODE_SQUARE;
        end
        bbc_pkg::CH_CLOSE_CURLY: begin
          close_want = 1'b1;
          want_code  = bbc_pkg::CODE_CURLY;
        end
        bbc_pkg::CH_CLOSE_ANGLE: begin
          close_want = 1'b1;
          want_code  = bbc_pkg::CODE_ANGLE;
        end
        default: begin
          failed_next = 1'b1;
        end
      endcase
      if (push_want) begin
        if (full) begin
          failed_next        = 1'b1;
          overflow_seen_next = 1'b1;
        end else begin
          ctl.push = 1'b1;
          ctl.code = push_code;
        end
      end
      if (close_want) begin
        if (empty) begin
          failed_next = 1'b1;
        end else begin
          ctl.pop = 1'b1;
          if (top_code != want_code) begin
            failed_next = 1'b1;
          end
        end
      end
      if (ctl.push) begin
        depth_next = depth + 1'b1;
      end else if (ctl.pop) begin
        depth_next = depth - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth         <= '0;
      failed        <= 1'b0;
      overflow_seen <= 1'b0;
      verdict.valid <= 1'b0;
    end else begin
      if (acc && chars.last_symbol) begin
        depth         <= '0;
        failed        <= 1'b0;
        overflow_seen <= 1'b0;
        verdict.valid <= 1'b1;
      end else begin
        depth         <= depth_next;
        failed        <= failed_next;
        overflow_seen <= overflow_seen_next;
        if (verdict.ready) begin
          verdict.valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && chars.last_symbol) begin
      verdict.balanced   <= !failed_next && (depth_next == '0);
      verdict.overflowed <= overflow_seen_next;
    end
  end

  `BBC_NEVER(a_depth_bound, clk, rst, depth > FULL)
  `BBC_NEVER(a_push_pop, clk, rst, ctl.push && ctl.pop)
  `BBC_ASSERT(a_shift_on_beat, clk, rst, (ctl.push || ctl.pop) |-> acc)
  `BBC_ASSERT(a_clear_after_last, clk, rst, (acc && chars.last_symbol) |=> (depth == '0 && !failed && !overflow_seen && verdict.valid))
  `BBC_ASSERT(a_fail_freezes, clk, rst, (failed && !(acc && chars.last_symbol)) |=> $stable(depth))

endmodule

@@ hw/rtl/bracket_balance_checker_core.sv @@
`timescale 1ns / 1ps
// bracket balance checker
// chars: one ascii character per beat on symbol, last_symbol high on the final
//   character of a string. verdict: one beat per string, balanced and
//   overflowed, emitted after the beat that carries last_symbol.
// openers ( [ { < push, a bar pops a bar on top or else pushes, closers must
//   pop their own opener; any other byte, an empty-stack closer, a mismatch
//   or a push into a full stack marks the string unbalanced.
// throughput: one character per cycle while chars.ready is high, no bubbles
//   between strings. every beat does at most one shift of the cell row, and
//   the top code is read straight from the first cell.
// output: registered, valid in the cycle after the last character is taken.
// reset: depth and flags clear and the verdict register empties; stack cells
//   keep stale contents, which are never read below the depth.
// stall: the verdict sits in a single output register; chars.ready stays high
//   while that register is empty or being drained, and drops only when a
//   verdict is held and verdict.ready is low.
// STACK_DEPTH sets the number of cells (nesting limit per string).
module bracket_balance_checker_core #(
  parameter int STACK_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  bbc_in_if.sink    chars,
  bbc_out_if.source verdict
);

  bbc_pkg::stack_ctl_t ctl;
  bbc_pkg::code_t      codes [STACK_DEPTH];

  bbc_ctrl #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .chars    (chars),
    .verdict  (verdict),
    .top_code (codes[0]),
    .ctl      (ctl)
  );

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    bbc_pkg::code_t from_prev;
    bbc_pkg::code_t from_next;

    if (i == 0) begin : g_head
      assign from_prev = ctl.code;
    end else begin : g_body
      assign from_prev = codes[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_tail
      assign from_next = bbc_pkg::CODE_ROUND;
    end else begin : g_link
      assign from_next = codes[i+1];
    end

    bbc_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .from_prev (from_prev),
      .from_next (from_next),
      .held      (codes[i])
    );
  end

endmodule
